>>> rtl/rgdr_pkg.sv
// ----------------------------------------------------------------------------
// rgdr_pkg
// Types and constants shared by the duck region detector and its testbench.
// ----------------------------------------------------------------------------
package rgdr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 31;
  localparam int THR_W    = 39;
  localparam int CNT_W    = 32;
  localparam int POS_W    = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_DOWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_UP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 3'd4;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 39'd107374182;
  localparam logic [CNT_W-1:0] HOLD_RST      = 32'd44100;
  localparam logic [CNT_W-1:0] FADE_RST      = 32'd22050;
  localparam logic [POS_W-1:0] START_POS_RST = 40'd0;

  typedef enum logic {
    KIND_AUDIO = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [SAMPLE_W-1:0]  sample;
  } sample_item_t;

  typedef struct packed {
    logic [POS_W-1:0] region_start;
    logic [POS_W-1:0] region_end;
    logic             closed_by_flush;
  } region_item_t;

endpackage

>>> rtl/rgdr_ram.sv
// ----------------------------------------------------------------------------
// rgdr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rgdr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rms_gate_duck_region_detector.sv
// Throughput: one item per cycle unless output stalls. A result is offered once the item
// that closes the region has left the update stage. The window RAM is read at accept and
// written as the item leaves that stage; the pointer never revisits an entry within two items.
// A full output register that is stalled holds the update stage, which then stalls input.
// Reset (synchronous): registers to defaults, sum and region state cleared; no RAM
// clearing pass, entries not yet written since reset read as zero via a wrap flag.
// ----------------------------------------------------------------------------
// rms_gate_duck_region_detector
// Moving sum of squares over a sample window, threshold gate with hold, and
// emission of widened duck regions.
// ----------------------------------------------------------------------------
module rms_gate_duck_region_detector #(
  parameter int WINDOW = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  rgdr_pkg::sample_item_t              sample_item,
  output logic                                region_valid,
  input  logic                                region_stall,
  output rgdr_pkg::region_item_t              region_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int SUM_W = rgdr_pkg::SQ_W + $clog2(WINDOW);
  localparam int CMP_W = (SUM_W > rgdr_pkg::THR_W) ? SUM_W : rgdr_pkg::THR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  // configuration
  logic [rgdr_pkg::THR_W-1:0] threshold;
  logic [rgdr_pkg::CNT_W-1:0] hold;
  logic [rgdr_pkg::CNT_W-1:0] fade_down;
  logic [rgdr_pkg::CNT_W-1:0] fade_up;

  // accept side
  logic             in_fire;
  logic             in_audio;
  logic [PTR_W-1:0] rd_ptr;
  logic             wrapped;
  logic [rgdr_pkg::MAG_W-1:0] mag;
  logic [2*rgdr_pkg::MAG_W-1:0] mag_sq;

  // update stage
  logic                      s2_valid;
  rgdr_pkg::kind_t           s2_kind;
  logic [rgdr_pkg::SQ_W-1:0] s2_sq;
  logic [PTR_W-1:0]          s2_ptr;
  logic                      s2_old_ok;
  logic                      s2_adv;
  logic [rgdr_pkg::SQ_W-1:0] ram_rdata;
  logic [rgdr_pkg::SQ_W-1:0] old_sq;

  logic [SUM_W-1:0]           square_sum;
  logic [SUM_W-1:0]           sum_next;
  logic                       loud;
  logic                       in_region;
  logic [rgdr_pkg::POS_W-1:0] open_start;
  logic [rgdr_pkg::CNT_W-1:0] quiet_count;
  logic [rgdr_pkg::CNT_W-1:0] quiet_inc;
  logic [rgdr_pkg::POS_W-1:0] position;
  logic [rgdr_pkg::POS_W-1:0] last_audio;
  logic [rgdr_pkg::POS_W-1:0] last_flush;
  logic                       close_audio;
  logic                       emit;

  // output register
  logic                       out_valid;
  logic [rgdr_pkg::POS_W-1:0] out_open;
  logic [rgdr_pkg::POS_W-1:0] out_last;
  logic                       out_flush;
  logic [rgdr_pkg::POS_W:0]   start_diff;
  logic [rgdr_pkg::POS_W:0]   end_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rgdr_pkg::THRESHOLD_RST;
      hold      <= rgdr_pkg::HOLD_RST;
      fade_down <= rgdr_pkg::FADE_RST;
      fade_up   <= rgdr_pkg::FADE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgdr_pkg::CFG_THRESHOLD: threshold <= cfg_data[rgdr_pkg::THR_W-1:0];
        rgdr_pkg::CFG_HOLD:      hold      <= cfg_data[rgdr_pkg::CNT_W-1:0];
        rgdr_pkg::CFG_FADE_DOWN: fade_down <= cfg_data[rgdr_pkg::CNT_W-1:0];
        rgdr_pkg::CFG_FADE_UP:   fade_up   <= cfg_data[rgdr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // accept side: square and read the oldest window entry
  assign s2_adv       = s2_valid && (!out_valid || !region_stall);
  assign sample_stall = s2_valid && !s2_adv;
  assign in_fire      = sample_valid && !sample_stall;
  assign in_audio     = in_fire && (sample_item.kind == rgdr_pkg::KIND_AUDIO);

  assign mag    = sample_item.sample[rgdr_pkg::SAMPLE_W-1]
                ? rgdr_pkg::MAG_W'(~sample_item.sample + 1'b1)
                : rgdr_pkg::MAG_W'(sample_item.sample);
  assign mag_sq = mag * mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wrapped <= 1'b0;
    end else if (in_audio) begin
      if (rd_ptr == PTR_LAST) begin
        rd_ptr  <= '0;
        wrapped <= 1'b1;
      end else begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_kind   <= sample_item.kind;
      s2_sq     <= mag_sq[rgdr_pkg::SQ_W-1:0];
      s2_ptr    <= rd_ptr;
      s2_old_ok <= wrapped;
    end
  end

  rgdr_ram #(
    .WIDTH(rgdr_pkg::SQ_W),
    .DEPTH(WINDOW)
  ) u_window (
    .clk  (clk),
    .we   (s2_adv && (s2_kind == rgdr_pkg::KIND_AUDIO)),
    .waddr(s2_ptr),
    .wdata(s2_sq),
    .re   (in_audio),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // update stage: running sum, gate and hold
  assign old_sq   = s2_old_ok ? ram_rdata : '0;
  assign sum_next = square_sum - SUM_W'(old_sq) + SUM_W'(s2_sq);
  assign loud     = CMP_W'(sum_next) > CMP_W'(threshold);

  assign quiet_inc   = (quiet_count == '1) ? quiet_count : quiet_count + 1'b1;
  assign close_audio = in_region && !loud && (quiet_inc >= hold);
  assign last_audio  = position - rgdr_pkg::POS_W'(quiet_inc);
  assign last_flush  = position + ~rgdr_pkg::POS_W'(quiet_count);
  assign emit        = (s2_kind == rgdr_pkg::KIND_FLUSH) ? in_region : close_audio;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum  <= '0;
      in_region   <= 1'b0;
      quiet_count <= '0;
      position    <= rgdr_pkg::START_POS_RST;
    end else if (cfg_valid && cfg_ready && (cfg_index == rgdr_pkg::CFG_START_POS)) begin
      position <= cfg_data[rgdr_pkg::POS_W-1:0];
    end else if (s2_adv) begin
      if (s2_kind == rgdr_pkg::KIND_FLUSH) begin
        in_region <= 1'b0;
      end else begin
        square_sum <= sum_next;
        position   <= position + 1'b1;
        if (loud) begin
          quiet_count <= '0;
          if (!in_region) begin
            in_region <= 1'b1;
          end
        end else if (in_region) begin
          quiet_count <= quiet_inc;
          if (close_audio) begin
            in_region <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && (s2_kind == rgdr_pkg::KIND_AUDIO) && loud && !in_region) begin
      open_start <= position;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv && emit) begin
      out_valid <= 1'b1;
    end else if (!region_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && emit) begin
      out_open  <= open_start;
      out_last  <= (s2_kind == rgdr_pkg::KIND_FLUSH) ? last_flush : last_audio;
      out_flush <= (s2_kind == rgdr_pkg::KIND_FLUSH);
    end
  end

  // widen by the fades, saturate at both ends
  assign start_diff = {1'b0, out_open} - (rgdr_pkg::POS_W + 1)'(fade_down);
  assign end_sum    = {1'b0, out_last} + (rgdr_pkg::POS_W + 1)'(fade_up);

  assign region_valid                 = out_valid;
  assign region_item.region_start     = start_diff[rgdr_pkg::POS_W]
                                      ? '0 : start_diff[rgdr_pkg::POS_W-1:0];
  assign region_item.region_end       = end_sum[rgdr_pkg::POS_W]
                                      ? '1 : end_sum[rgdr_pkg::POS_W-1:0];
  assign region_item.closed_by_flush  = out_flush;

`ifndef SYNTH
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rd_ptr <= PTR_LAST))
    else $error("window pointer beyond window");

  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && emit) |=> !in_region)
    else $error("region still open after emitting");

  a_open_quiet: assert property (@(posedge clk) disable iff (rst)
    $rose(in_region) |-> (quiet_count == '0))
    else $error("region opened with nonzero quiet count");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped)
    else $error("wrap flag cleared without reset");
`endif

endmodule

>>> tb/tb_rms_gate_duck_region_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rms_gate_duck_region_detector
// Drives control-track samples and flush items into the duck region detector
// with random gaps and output stalls. A tracker keeps its own moving sum of
// squares, gate and hold state, predicts every widened region and checks each
// emitted region field by field. A directed opening covers the threshold
// boundary, wrap, saturation, zero and lowered hold and flush closing. Random
// phases of bursty samples follow under changing register settings.
// ----------------------------------------------------------------------------
module tb_rms_gate_duck_region_detector;
  import rgdr_pkg::*;

  localparam int WINDOW = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_START_POS + 1'b1;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_EDGE = 40'd3221159939;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_TOP = {{(CFG_DATA_W-THR_W){1'b0}}, {THR_W{1'b1}}};

  class region_tracker;
    logic [THR_W-1:0] threshold;
    logic [CNT_W-1:0] hold;
    logic [CNT_W-1:0] fade_down;
    logic [CNT_W-1:0] fade_up;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] open_start;
    logic [CNT_W-1:0] quiet_count;
    logic [SQ_W-1:0]  squares [WINDOW];
    logic [36:0]      sq_sum;
    int               slot;
    bit               open;
    region_item_t     due [$];
    int               samples;
    int               flushes;
    int               checked;
    int               flush_closed;
    int               errors;

    function new();
      threshold = THRESHOLD_RST;
      hold = HOLD_RST;
      fade_down = FADE_RST;
      fade_up = FADE_RST;
      position = START_POS_RST;
      open_start = '0;
      quiet_count = '0;
      foreach (squares[i]) squares[i] = '0;
      sq_sum = '0;
      slot = 0;
      open = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: threshold = data[THR_W-1:0];
        CFG_HOLD:      hold = data[CNT_W-1:0];
        CFG_FADE_DOWN: fade_down = data[CNT_W-1:0];
        CFG_FADE_UP:   fade_up = data[CNT_W-1:0];
        CFG_START_POS: position = data[POS_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_region(logic [POS_W-1:0] last_loud, bit by_flush);
      region_item_t r;
      logic [POS_W:0] stretched;
      stretched = {1'b0, last_loud} + fade_up;
      r.region_start = (open_start >= fade_down) ? open_start - fade_down : '0;
      r.region_end = stretched[POS_W] ? {POS_W{1'b1}} : stretched[POS_W-1:0];
      r.closed_by_flush = by_flush;
      due.push_back(r);
      open = 1'b0;
      if (by_flush) flush_closed++;
    endfunction

    function void take_sample(sample_item_t it);
      logic [MAG_W-1:0] mag;
      logic [SQ_W-1:0]  sq;
      logic [POS_W-1:0] here;
      if (it.kind == KIND_FLUSH) begin
        flushes++;
        if (open) close_region(position - 1'b1 - POS_W'(quiet_count), 1'b1);
        return;
      end
      samples++;
      mag = it.sample[SAMPLE_W-1] ? MAG_W'(-it.sample) : MAG_W'(it.sample);
      sq = SQ_W'(mag) * SQ_W'(mag);
      here = position;
      sq_sum = sq_sum - squares[slot] + sq;
      squares[slot] = sq;
      slot = (slot + 1) % WINDOW;
      position = position + 1'b1;
      if (sq_sum > threshold) begin
        quiet_count = '0;
        if (!open) begin
          open = 1'b1;
          open_start = here;
        end
      end else if (open) begin
        if (quiet_count != {CNT_W{1'b1}}) quiet_count++;
        if (quiet_count >= hold) close_region(here - POS_W'(quiet_count), 1'b0);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void report(string field, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void match_region(region_item_t got);
      region_item_t want;
      if (due.size() == 0) begin
        report("region with none due, region_start", '0, got.region_start);
        return;
      end
      want = due.pop_front();
      checked++;
      if (got.region_start !== want.region_start)
        report("region_start", want.region_start, got.region_start);
      if (got.region_end !== want.region_end)
        report("region_end", want.region_end, got.region_end);
      if (got.closed_by_flush !== want.closed_by_flush)
        report("closed_by_flush", POS_W'(want.closed_by_flush), POS_W'(got.closed_by_flush));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_item_t          sample_item = '0;
  logic                  region_valid;
  logic                  region_stall = 1'b0;
  region_item_t          region_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    no_gaps = 1'b0;
  region_tracker         regions;

  rms_gate_duck_region_detector #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .region_valid (region_valid),
    .region_stall (region_stall),
    .region_item  (region_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    region_stall <= !no_gaps && ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk) begin
    if (!rst && region_valid && !region_stall) begin
      regions.match_region(region_item);
    end
  end

  task automatic send_item(input kind_t k, input int v);
    sample_item_t it;
    it.kind = k;
    it.sample = SAMPLE_W'(v);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 27) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_item <= it;
    do @(posedge clk); while (sample_stall);
    regions.take_sample(it);
  endtask

  // hold input until every due region is out and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (regions.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    regions.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_fade();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(1, 1000));
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'(32'hFFFF_FFFF);
    endcase
  endfunction

  initial begin
    #4_000_000;
    $display("[rms_gate_duck_region_detector] ERROR");
    $finish;
  end

  initial begin
    int phase;
    int seg_left;
    int seg_kind;
    int mag;
    logic [CFG_DATA_W-1:0] value;
    regions = new();
    phase = 0;
    seg_left = 0;
    seg_kind = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: flush with nothing open, then open at position zero and flush
    send_item(KIND_FLUSH, 0);
    send_item(KIND_AUDIO, -32768);
    send_item(KIND_AUDIO, 32767);
    send_item(KIND_AUDIO, 0);
    send_item(KIND_AUDIO, 1);
    send_item(KIND_AUDIO, -1);
    send_item(KIND_FLUSH, -1);
    settle();

    // threshold equal to the next sum, position just below the wrap
    cfg_write(CFG_THRESHOLD, THRESHOLD_EDGE);
    cfg_write(CFG_HOLD, 40'd1000);
    cfg_write(CFG_FADE_DOWN, 40'd5);
    cfg_write(CFG_FADE_UP, 40'hFF_FFFF_FFFF);
    cfg_write(CFG_START_POS, 40'hFF_FFFF_FFFE);
    for (int i = CFG_FIRST_SPARE; i < 2 ** CFG_IDX_W; i++) begin
      cfg_write(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
    end
    send_item(KIND_AUDIO, -32768);
    send_item(KIND_AUDIO, 32767);
    settle();

    // quiet while open, then flush across the wrap with a saturated end
    cfg_write(CFG_THRESHOLD, THRESHOLD_TOP);
    send_item(KIND_AUDIO, 0);
    send_item(KIND_AUDIO, 0);
    send_item(KIND_FLUSH, 0);
    settle();

    // zero hold closes on the first quiet sample
    cfg_write(CFG_THRESHOLD, '0);
    send_item(KIND_AUDIO, 5);
    settle();
    cfg_write(CFG_HOLD, '0);
    cfg_write(CFG_THRESHOLD, THRESHOLD_TOP);
    send_item(KIND_AUDIO, 7);
    settle();

    // lower the hold below the quiet count of an open region
    cfg_write(CFG_THRESHOLD, '0);
    cfg_write(CFG_HOLD, 40'd1000);
    send_item(KIND_AUDIO, -3);
    settle();
    cfg_write(CFG_THRESHOLD, THRESHOLD_TOP);
    send_item(KIND_AUDIO, 0);
    send_item(KIND_AUDIO, 0);
    settle();
    cfg_write(CFG_HOLD, 40'd1);
    send_item(KIND_AUDIO, 0);

    while (regions.samples < 700) begin
      settle();
      no_gaps = 1'b0;
      case (phase % 8)
        1: value = '0;
        5: value = THRESHOLD_TOP;
        default: value = (CFG_DATA_W'($urandom_range(4, 70)) << 29)
                         | CFG_DATA_W'($urandom_range(0, (1 << 29) - 1));
      endcase
      cfg_write(CFG_THRESHOLD, value);
      case ($urandom_range(0, 3))
        0: value = '0;
        1: value = 40'd1;
        2: value = CFG_DATA_W'($urandom_range(2, 40));
        default: value = CFG_DATA_W'($urandom_range(0, 150));
      endcase
      if (phase % 8 == 6) value = 40'hFF_FFFF_FFFF;
      cfg_write(CFG_HOLD, value);
      cfg_write(CFG_FADE_DOWN, pick_fade());
      cfg_write(CFG_FADE_UP, pick_fade());
      case ($urandom_range(0, 3))
        0: cfg_write(CFG_START_POS, '0);
        1: cfg_write(CFG_START_POS, CFG_DATA_W'({$urandom, $urandom}));
        2: cfg_write(CFG_START_POS, 40'hFF_FFFF_FFFF - CFG_DATA_W'($urandom_range(0, 300)));
        default: ;
      endcase
      no_gaps = (phase == 2);
      repeat (100) begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 9);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        if ($urandom_range(0, 99) < 3) begin
          send_item(KIND_FLUSH, $urandom_range(0, 65535));
        end else begin
          if (seg_kind < 4) mag = $urandom_range(16000, 32767);
          else if (seg_kind < 8) mag = $urandom_range(0, 400);
          else mag = $urandom_range(0, 65535);
          if (seg_kind < 8 && $urandom_range(0, 1)) mag = -mag;
          send_item(KIND_AUDIO, mag);
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
    settle();

    $display("Run covered %0d samples and %0d flush items over %0d random settings",
             regions.samples, regions.flushes, phase);
    $display("Regions compared: %0d, of which %0d closed by flush",
             regions.checked, regions.flush_closed);
    if (regions.errors == 0) begin
      $display("[rms_gate_duck_region_detector] OK");
    end else begin
      $display("[rms_gate_duck_region_detector] ERROR");
    end
    $finish;
  end

endmodule

>>> rms_gate_duck_region_detector.f
rtl/rgdr_pkg.sv
rtl/rgdr_ram.sv
rtl/rms_gate_duck_region_detector.sv
tb/tb_rms_gate_duck_region_detector.sv
